// ===== rtl/siu_pkg.sv =====
// ============================================================================
// siu_pkg: shared types for the SPARC integer execute unit
// Operation codes and the packed payload structs of the input and result
// channels.
// ============================================================================
`default_nettype none

package siu_pkg;

  typedef enum logic [4:0] {
    CMD_ADD     = 5'd0,
    CMD_ADDCC   = 5'd1,
    CMD_ADDX    = 5'd2,
    CMD_ADDXCC  = 5'd3,
    CMD_SUB     = 5'd4,
    CMD_SUBCC   = 5'd5,
    CMD_SUBX    = 5'd6,
    CMD_SUBXCC  = 5'd7,
    CMD_MULSCC  = 5'd8,
    CMD_AND     = 5'd9,
    CMD_ANDCC   = 5'd10,
    CMD_ANDN    = 5'd11,
    CMD_ANDNCC  = 5'd12,
    CMD_OR      = 5'd13,
    CMD_ORCC    = 5'd14,
    CMD_ORN     = 5'd15,
    CMD_ORNCC   = 5'd16,
    CMD_XOR     = 5'd17,
    CMD_XORCC   = 5'd18,
    CMD_XNOR    = 5'd19,
    CMD_XNORCC  = 5'd20,
    CMD_SLL     = 5'd21,
    CMD_SRL     = 5'd22,
    CMD_SRA     = 5'd23,
    CMD_SETHI   = 5'd24,
    CMD_SAVE    = 5'd25,
    CMD_RESTORE = 5'd26,
    CMD_RDPSR   = 5'd27,
    CMD_RDY     = 5'd28,
    CMD_WRPSR   = 5'd29,
    CMD_WRY     = 5'd30
  } siu_cmd_t;

  // The one code with no operation behind it; it executes as a no-op.
  localparam logic [4:0] CmdUnused = 5'd31;

  // Position of the integer condition codes n, z, v, c in the PSR.
  localparam int unsigned IccLsb = 20;
  localparam int unsigned IccMsb = 23;

  typedef struct packed {
    logic [4:0]  command;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    logic        use_immediate;
    logic [12:0] imm13;
    logic [21:0] imm22;
    logic        dest_is_zero;
    logic [31:0] psr_in;
    logic [31:0] y_in;
  } siu_in_beat_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [31:0] y_out;
    logic [31:0] psr_out;
  } siu_out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/sparc_integer_execute_unit.sv =====
// ============================================================================
// sparc_integer_execute_unit: SPARC V8 integer execute unit
// An accepted beat enters the input register, its result the result register.
// Throughput: one instruction per cycle; input and result registers stall
// independently under out_ready backpressure.
// Reset: rst_n is synchronous, active low, and clears both valid flags.
// ============================================================================
`default_nettype none

module sparc_integer_execute_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire siu_pkg::siu_in_beat_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output siu_pkg::siu_out_beat_t      out_data
);

  // The design is a two-register pipe. The input register captures the issued
  // instruction; the datapath between it and the result register is purely
  // combinational (32-bit adders plus selection). Each register advances
  // whenever the stage after it is empty or draining, so a new beat enters in
  // every cycle as long as the consumer keeps taking results. While a result
  // waits on out_ready, the input register can still hold one more beat.

  siu_pkg::siu_in_beat_t  s1_data_r;
  siu_pkg::siu_in_beat_t  s1_data_nxt;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  siu_pkg::siu_out_beat_t out_data_r;
  siu_pkg::siu_out_beat_t out_data_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  siu_pkg::siu_out_beat_t alu_res;
  logic                   s1_adv;
  logic                   in_acc;

  siu_alu u_alu (
    .op_i  (s1_data_r),
    .res_o (alu_res)
  );

  // The first stage may move forward when the result register is free or
  // being emptied this cycle.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_data_nxt   = s1_data_r;
    s1_valid_nxt  = s1_valid_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
      if (s1_valid_r) begin
        out_data_nxt = alu_res;
      end
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_data;
    end
  end

  // Payload registers carry no reset; only the valid flags are cleared.
  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted beat always lands in the input register.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted beat did not reach the input register");

  // A beat leaving the input register shows up as a result.
  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("advanced beat was lost before the result register");

  // A blocked input stage holds its beat untouched.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("stalled input stage changed");

  // With the result register stalled, the input stage never takes a second beat.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full");

endmodule

`default_nettype wire

// ===== rtl/siu_alu.sv =====
// ============================================================================
// siu_alu: integer datapath
// Combinational execution of one instruction: operand select, add/subtract,
// multiply step, logic, shifts, special register moves and icc generation.
// ============================================================================
`default_nettype none

module siu_alu (
  input  wire siu_pkg::siu_in_beat_t op_i,
  output siu_pkg::siu_out_beat_t     res_o
);

  // Flags returned as {n, z, v, c}.
  function automatic logic [3:0] add_icc(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] r);
    logic v;
    logic c;
    begin
      v = (a[31] & b[31] & ~r[31]) | (~a[31] & ~b[31] & r[31]);
      c = (a[31] & b[31]) | (~r[31] & (a[31] | b[31]));
      add_icc = {r[31], (r == 32'd0), v, c};
    end
  endfunction

  function automatic logic [3:0] sub_icc(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] r);
    logic v;
    logic c;
    begin
      v = (a[31] & ~b[31] & ~r[31]) | (~a[31] & b[31] & r[31]);
      c = (~a[31] & b[31]) | (r[31] & (~a[31] | b[31]));
      sub_icc = {r[31], (r == 32'd0), v, c};
    end
  endfunction

  siu_pkg::siu_cmd_t cmd;
  logic [31:0] op2;
  logic [4:0]  sh;
  logic        carry;
  logic [31:0] add_res;
  logic [31:0] sub_res;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_res;
  logic [31:0] logic_res;
  logic [31:0] res;
  logic [31:0] y_new;
  logic [31:0] psr_new;
  logic [3:0]  icc;
  logic        set_icc;

  assign cmd   = siu_pkg::siu_cmd_t'(op_i.command);
  assign op2   = op_i.use_immediate ? {{19{op_i.imm13[12]}}, op_i.imm13} : op_i.rs2_value;
  assign sh    = op2[4:0];
  assign carry = op_i.psr_in[siu_pkg::IccLsb];

  // Extended forms fold the incoming carry into the same adder or subtractor.
  always_comb begin
    add_res = op_i.rs1_value + op2 +
              {31'd0, carry & (cmd == siu_pkg::CMD_ADDX || cmd == siu_pkg::CMD_ADDXCC)};
    sub_res = op_i.rs1_value - op2 -
              {31'd0, carry & (cmd == siu_pkg::CMD_SUBX || cmd == siu_pkg::CMD_SUBXCC)};
  end

  // Multiply step: shift rs1 right with n xor v on top, add op2 when y[0] is set.
  assign mul_a   = {op_i.psr_in[siu_pkg::IccMsb] ^ op_i.psr_in[siu_pkg::IccMsb - 2],
                    op_i.rs1_value[31:1]};
  assign mul_b   = op_i.y_in[0] ? op2 : 32'd0;
  assign mul_res = mul_a + mul_b;

  always_comb begin
    case (cmd) inside
      siu_pkg::CMD_AND,  siu_pkg::CMD_ANDCC:  logic_res = op_i.rs1_value & op2;
      siu_pkg::CMD_ANDN, siu_pkg::CMD_ANDNCC: logic_res = op_i.rs1_value & ~op2;
      siu_pkg::CMD_OR,   siu_pkg::CMD_ORCC:   logic_res = op_i.rs1_value | op2;
      siu_pkg::CMD_ORN,  siu_pkg::CMD_ORNCC:  logic_res = op_i.rs1_value | ~op2;
      siu_pkg::CMD_XOR,  siu_pkg::CMD_XORCC:  logic_res = op_i.rs1_value ^ op2;
      default:                                logic_res = op_i.rs1_value ^ ~op2;
    endcase
  end

  always_comb begin
    res     = 32'd0;
    y_new   = op_i.y_in;
    psr_new = op_i.psr_in;
    icc     = 4'd0;
    set_icc = 1'b0;
    case (cmd) inside
      siu_pkg::CMD_ADD, siu_pkg::CMD_ADDX: begin
        res = add_res;
      end
      siu_pkg::CMD_ADDCC, siu_pkg::CMD_ADDXCC: begin
        res     = add_res;
        icc     = add_icc(op_i.rs1_value, op2, add_res);
        set_icc = 1'b1;
      end
      siu_pkg::CMD_SUB, siu_pkg::CMD_SUBX: begin
        res = sub_res;
      end
      siu_pkg::CMD_SUBCC, siu_pkg::CMD_SUBXCC: begin
        res     = sub_res;
        icc     = sub_icc(op_i.rs1_value, op2, sub_res);
        set_icc = 1'b1;
      end
      siu_pkg::CMD_MULSCC: begin
        res     = mul_res;
        y_new   = {op_i.rs1_value[0], op_i.y_in[31:1]};
        icc     = add_icc(mul_a, mul_b, mul_res);
        set_icc = 1'b1;
      end
      siu_pkg::CMD_AND, siu_pkg::CMD_ANDN, siu_pkg::CMD_OR, siu_pkg::CMD_ORN,
      siu_pkg::CMD_XOR, siu_pkg::CMD_XNOR: begin
        res = logic_res;
      end
      siu_pkg::CMD_ANDCC, siu_pkg::CMD_ANDNCC, siu_pkg::CMD_ORCC, siu_pkg::CMD_ORNCC,
      siu_pkg::CMD_XORCC, siu_pkg::CMD_XNORCC: begin
        res     = logic_res;
        icc     = {logic_res[31], (logic_res == 32'd0), 2'b00};
        set_icc = 1'b1;
      end
      siu_pkg::CMD_SLL: res = op_i.rs1_value << sh;
      siu_pkg::CMD_SRL: res = op_i.rs1_value >> sh;
      siu_pkg::CMD_SRA: res = 32'($signed(op_i.rs1_value) >>> sh);
      siu_pkg::CMD_SETHI: res = {op_i.imm22, 10'd0};
      siu_pkg::CMD_SAVE, siu_pkg::CMD_RESTORE: res = add_res;
      siu_pkg::CMD_RDPSR: res = op_i.psr_in;
      siu_pkg::CMD_RDY:   res = op_i.y_in;
      siu_pkg::CMD_WRPSR: psr_new = op_i.rs1_value;
      siu_pkg::CMD_WRY:   y_new = op_i.rs1_value;
      default: begin
        // Unassigned code: no operation.
        res = 32'd0;
      end
    endcase
    if (set_icc) begin
      psr_new[siu_pkg::IccMsb:siu_pkg::IccLsb] = icc;
    end
    if (op_i.dest_is_zero || cmd == siu_pkg::CMD_WRPSR || cmd == siu_pkg::CMD_WRY ||
        op_i.command == siu_pkg::CmdUnused) begin
      res = 32'd0;
    end
  end

  assign res_o.result_value = res;
  assign res_o.y_out        = y_new;
  assign res_o.psr_out      = psr_new;

endmodule

`default_nettype wire
